FILE: src/basic_accumulator_cpu_step_assert.svh
// Assertion macros shared by the checker of the accumulator machine.
`ifndef BASIC_ACCUMULATOR_CPU_STEP_ASSERT_SVH
`define BASIC_ACCUMULATOR_CPU_STEP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BAC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bac check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define BAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bac check failed");

`endif

FILE: src/bac_pkg.sv
`default_nettype none

package bac_pkg;

    localparam int ADDR_W = 12;
    localparam int WORD_W = 16;
    localparam int MEM_DEPTH = 4096;

    // Item modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;

    // Memory-reference opcodes (bits 14..12)
    localparam logic [2:0] OP_AND = 3'd0;
    localparam logic [2:0] OP_ADD = 3'd1;
    localparam logic [2:0] OP_LDA = 3'd2;
    localparam logic [2:0] OP_STA = 3'd3;
    localparam logic [2:0] OP_BUN = 3'd4;
    localparam logic [2:0] OP_BSA = 3'd5;
    localparam logic [2:0] OP_ISZ = 3'd6;
    localparam logic [2:0] OP_REG = 3'd7;

    // Register-reference patterns (bits 11..0)
    localparam logic [ADDR_W-1:0] REG_CLA = 12'h800;
    localparam logic [ADDR_W-1:0] REG_CLE = 12'h400;
    localparam logic [ADDR_W-1:0] REG_CMA = 12'h200;
    localparam logic [ADDR_W-1:0] REG_CME = 12'h100;
    localparam logic [ADDR_W-1:0] REG_CIR = 12'h080;
    localparam logic [ADDR_W-1:0] REG_CIL = 12'h040;
    localparam logic [ADDR_W-1:0] REG_INC = 12'h020;
    localparam logic [ADDR_W-1:0] REG_SPA = 12'h010;
    localparam logic [ADDR_W-1:0] REG_SNA = 12'h008;
    localparam logic [ADDR_W-1:0] REG_SZA = 12'h004;
    localparam logic [ADDR_W-1:0] REG_SZE = 12'h002;
    localparam logic [ADDR_W-1:0] REG_HLT = 12'h001;

    // Architectural registers of the machine
    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [WORD_W-1:0] acc;
        logic              e;
        logic              halt;
    } bac_regs_t;

endpackage

`default_nettype wire

FILE: src/bac_ram.sv
`default_nettype none

module bac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read-first, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: src/bac_regop.sv
`default_nettype none

module bac_regop (
    input  wire logic [bac_pkg::ADDR_W-1:0] pattern,
    input  wire bac_pkg::bac_regs_t         cur,
    output bac_pkg::bac_regs_t              nxt
);

    import bac_pkg::*;

    logic [WORD_W:0] inc_sum;

    assign inc_sum = {1'b0, cur.acc} + {{WORD_W{1'b0}}, 1'b1};

    // Apply one register-reference operation; cur.pc is already past the instruction
    always_comb
    begin
        nxt = cur;
        case (pattern)
            REG_CLA: nxt.acc = '0;
            REG_CLE: nxt.e = 1'b0;
            REG_CMA: nxt.acc = ~cur.acc;
            REG_CME: nxt.e = ~cur.e;
            REG_CIR:
            begin
                nxt.acc = {cur.e, cur.acc[WORD_W-1:1]};
                nxt.e   = cur.acc[0];
            end
            REG_CIL:
            begin
                nxt.acc = {cur.acc[WORD_W-2:0], cur.e};
                nxt.e   = cur.acc[WORD_W-1];
            end
            REG_INC:
            begin
                nxt.acc = inc_sum[WORD_W-1:0];
                nxt.e   = inc_sum[WORD_W];
            end
            REG_SPA: if (!cur.acc[WORD_W-1]) nxt.pc = cur.pc + 1'b1;
            REG_SNA: if (cur.acc[WORD_W-1]) nxt.pc = cur.pc + 1'b1;
            REG_SZA: if (cur.acc == '0) nxt.pc = cur.pc + 1'b1;
            REG_SZE: if (!cur.e) nxt.pc = cur.pc + 1'b1;
            REG_HLT: nxt.halt = 1'b1;
            default: nxt = cur;
        endcase
    end

endmodule

`default_nettype wire

FILE: src/basic_accumulator_cpu_step.sv
// 16-bit accumulator machine with 4096 words of main memory held in one
// single-port synchronous RAM. Each input word carries a mode: write a memory
// word, read a memory word, or execute one instruction at the program counter
// unless halted (fetch, optional indirect step, memory- or register-reference
// operation). Every input word produces exactly one output word showing the
// read data (zero unless reading) and PC, AC, E and the halt flag after it.
// Timing: one item is in flight at a time; the RAM port sets the pace. A write
// item writes at accept, a no-op touches no memory, a read adds one RAM read,
// and an executed instruction has a fetch, then at most an indirect read and
// an operand read with its write-back, each one RAM access. A new item is
// taken while an earlier result still waits in the output register. After
// reset the RAM is swept to zero one word a cycle, during which in_ready stays low.
// The start_address port is always ready; a write also loads the PC and is
// meant to be issued only while the machine is idle.
`default_nettype none

module basic_accumulator_cpu_step (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // item channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 mode,
    input  wire logic [bac_pkg::ADDR_W-1:0] address,
    input  wire logic [bac_pkg::WORD_W-1:0] data,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [bac_pkg::WORD_W-1:0] read_data,
    output logic      [bac_pkg::ADDR_W-1:0] pc_value,
    output logic      [bac_pkg::WORD_W-1:0] acc_value,
    output logic                            extend_bit,
    output logic                            halted,
    // configuration channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bac_pkg::ADDR_W-1:0] start_address
);

    import bac_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_FETCH,
        S_INDIR,
        S_OPER,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    bac_regs_t         regs_reg, regs_next;
    logic [WORD_W-1:0] ir_reg, ir_next;
    logic [ADDR_W-1:0] ea_reg, ea_next;
    logic [WORD_W-1:0] rd_reg, rd_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_rd_reg, out_rd_next;
    bac_regs_t         out_regs_reg, out_regs_next;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    // register-reference unit
    bac_regs_t         regop_in;
    bac_regs_t         regop_out;

    // dispatch of memory-reference operations
    logic              disp_go;
    logic [2:0]        disp_op;
    logic [ADDR_W-1:0] disp_ea;
    logic [ADDR_W-1:0] pc_adv;
    logic [WORD_W:0]   add_sum;
    logic [WORD_W-1:0] isz_val;
    logic              in_fire;

    bac_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Register ops see the PC already past the instruction
    assign regop_in = '{pc: regs_reg.pc + 1'b1, acc: regs_reg.acc, e: regs_reg.e,
                        halt: regs_reg.halt};

    bac_regop u_regop (
        .pattern (ram_rdata[ADDR_W-1:0]),
        .cur     (regop_in),
        .nxt     (regop_out)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign add_sum = {1'b0, regs_reg.acc} + {1'b0, ram_rdata};
    assign isz_val = ram_rdata + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        start_next     = start_reg;
        regs_next      = regs_reg;
        ir_next        = ir_reg;
        ea_next        = ea_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_regs_next  = out_regs_reg;

        ram_we    = 1'b0;
        ram_addr  = regs_reg.pc;
        ram_wdata = regs_reg.acc;

        disp_go = 1'b0;
        disp_op = (state_reg == S_FETCH) ? ram_rdata[14:12] : ir_reg[14:12];
        disp_ea = ram_rdata[ADDR_W-1:0];
        pc_adv  = (state_reg == S_FETCH) ? regs_reg.pc + 1'b1 : regs_reg.pc;

        // Drop the result word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the RAM to zero after reset
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_next    = '0;
                    state_next = S_DONE;
                    case (mode)
                        MODE_WRITE:
                        begin
                            ram_we    = 1'b1;
                            ram_addr  = address;
                            ram_wdata = data;
                        end
                        MODE_READ:
                        begin
                            ram_addr   = address;
                            state_next = S_READ;
                        end
                        MODE_EXEC:
                        begin
                            // Fetch the instruction unless halted
                            if (!regs_reg.halt)
                            begin
                                state_next = S_FETCH;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_READ:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_FETCH:
            begin
                ir_next      = ram_rdata;
                regs_next.pc = regs_reg.pc + 1'b1;
                if (ram_rdata[14:12] == OP_REG)
                begin
                    // Input/output group (indirect bit set) does nothing
                    if (!ram_rdata[WORD_W-1])
                    begin
                        regs_next = regop_out;
                    end
                    state_next = S_DONE;
                end
                else if (ram_rdata[WORD_W-1])
                begin
                    ram_addr   = ram_rdata[ADDR_W-1:0];
                    state_next = S_INDIR;
                end
                else
                begin
                    disp_go = 1'b1;
                end
            end
            S_INDIR:
            begin
                disp_go = 1'b1;
            end
            S_OPER:
            begin
                ram_addr   = ea_reg;
                state_next = S_DONE;
                case (ir_reg[14:12])
                    OP_AND: regs_next.acc = regs_reg.acc & ram_rdata;
                    OP_ADD:
                    begin
                        regs_next.acc = add_sum[WORD_W-1:0];
                        regs_next.e   = add_sum[WORD_W];
                    end
                    OP_LDA: regs_next.acc = ram_rdata;
                    OP_ISZ:
                    begin
                        // Write back the incremented word, skip on zero
                        ram_we    = 1'b1;
                        ram_wdata = isz_val;
                        if (isz_val == '0)
                        begin
                            regs_next.pc = regs_reg.pc + 1'b1;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = rd_reg;
                    out_regs_next  = regs_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Memory-reference dispatch with the effective address in hand
        if (disp_go)
        begin
            ea_next    = disp_ea;
            state_next = S_DONE;
            case (disp_op)
                OP_AND, OP_ADD, OP_LDA, OP_ISZ:
                begin
                    ram_addr   = disp_ea;
                    state_next = S_OPER;
                end
                OP_STA:
                begin
                    ram_we    = 1'b1;
                    ram_addr  = disp_ea;
                    ram_wdata = regs_reg.acc;
                end
                OP_BUN: regs_next.pc = disp_ea;
                OP_BSA:
                begin
                    ram_we       = 1'b1;
                    ram_addr     = disp_ea;
                    ram_wdata    = {{(WORD_W-ADDR_W){1'b0}}, pc_adv};
                    regs_next.pc = disp_ea + 1'b1;
                end
                default: state_next = S_DONE;
            endcase
        end

        // Start address write also loads the PC
        if (cfg_valid && cfg_ready)
        begin
            start_next   = start_address;
            regs_next.pc = start_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= '0;
            regs_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            start_reg     <= start_next;
            regs_reg      <= regs_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ir_reg       <= ir_next;
        ea_reg       <= ea_next;
        rd_reg       <= rd_next;
        out_rd_reg   <= out_rd_next;
        out_regs_reg <= out_regs_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_rd_reg;
    assign pc_value   = out_regs_reg.pc;
    assign acc_value  = out_regs_reg.acc;
    assign extend_bit = out_regs_reg.e;
    assign halted     = out_regs_reg.halt;

endmodule

`default_nettype wire

FILE: src/bac_checker.sv
`default_nettype none

`include "basic_accumulator_cpu_step_assert.svh"

module bac_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [bac_pkg::WORD_W-1:0] read_data,
    input wire logic [bac_pkg::ADDR_W-1:0] pc_value,
    input wire logic [bac_pkg::WORD_W-1:0] acc_value,
    input wire logic                       halted
);

    // One item in flight: no accept in the cycle after an accept
    `BAC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // A stalled result word holds its contents
    `BAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(pc_value) && $stable(acc_value))

    // Halt is sticky across result words
    `BAC_ASSERT_IMPLY(a_halt_sticky, out_valid && out_ready && halted ##1 out_valid, halted)

endmodule

bind basic_accumulator_cpu_step bac_checker u_bac_checker (.*);

`default_nettype wire
